>>> hw/rtl/skt_pkg.sv
// Package for the sorted key table find-or-insert unit.
// Holds the controller state type; no dependencies.
package skt_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMPARE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INSERT,
    ST_REPLY
  } skt_state_e;

endpackage

>>> hw/rtl/skt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module skt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> hw/rtl/sorted_key_table_find_or_insert_unit.sv
// Steps: accept, then a search and a compare state per binary search probe
// (at most ceil(log2(count+1)) probes), a search state to close a miss and,
// unless the table is full, a read and a write state per entry shifted up
// and an insert write; then the result loads into the output register.
// One key at a time; one registered RAM read port sets probe and shift cost.
// Reset clears the key count and the output valid; the key RAM is not cleared.
module sorted_key_table_find_or_insert_unit
  import skt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned KEY_BITS    = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [63:0]                          key_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 found_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]     position_o,
  output logic                                 table_full_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]     entries_used_o
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);

  skt_state_e state_q, state_d;

  logic [KEY_BITS-1:0] key_q, key_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     lo_q, lo_d;
  logic [CntW-1:0]     hi_q, hi_d;
  logic [AddrW-1:0]    ptr_q, ptr_d;
  logic                hit_q, hit_d;
  logic                full_q, full_d;

  logic                out_valid_q, out_valid_d;
  logic                found_q, found_d;
  logic [CntW-1:0]     position_q, position_d;
  logic                table_full_q, table_full_d;
  logic [CntW-1:0]     used_q, used_d;

  logic [CntW:0]       mid_sum;
  logic [CntW-1:0]     mid;
  logic                in_xfer;
  logic                out_free;
  logic                table_at_max;

  logic                ram_we;
  logic [AddrW-1:0]    ram_waddr;
  logic [KEY_BITS-1:0] ram_wdata;
  logic                ram_re;
  logic [AddrW-1:0]    ram_raddr;
  logic [KEY_BITS-1:0] ram_rdata;

  assign mid_sum      = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid          = mid_sum[CntW:1];
  assign in_xfer      = in_valid_i && in_ready_o;
  assign out_free     = !out_valid_q || out_ready_i;
  assign table_at_max = (count_q == CntW'(TABLE_DEPTH));

  skt_ram #(
    .WIDTH(KEY_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (lo_q < hi_q) begin
          state_d = ST_COMPARE;
        end else if (table_at_max) begin
          state_d = ST_REPLY;
        end else if (count_q > lo_q) begin
          state_d = ST_SHIFT_RD;
        end else begin
          state_d = ST_INSERT;
        end
      end
      ST_COMPARE: begin
        if (key_q == ram_rdata) state_d = ST_REPLY;
        else                    state_d = ST_SEARCH;
      end
      ST_SHIFT_RD: state_d = ST_SHIFT_WR;
      ST_SHIFT_WR: begin
        if (ptr_q == lo_q[AddrW-1:0]) state_d = ST_INSERT;
        else                          state_d = ST_SHIFT_RD;
      end
      ST_INSERT: state_d = ST_REPLY;
      ST_REPLY: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    ram_re     = 1'b0;
    ram_raddr  = mid[AddrW-1:0];
    ram_we     = 1'b0;
    ram_waddr  = lo_q[AddrW-1:0];
    ram_wdata  = key_q;
    case (state_q)
      ST_SEARCH: begin
        ram_re = (lo_q < hi_q);
      end
      ST_SHIFT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = ptr_q;
      end
      ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q + AddrW'(1);
        ram_wdata = ram_rdata;
      end
      ST_INSERT: begin
        ram_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    key_d        = key_q;
    count_d      = count_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    ptr_d        = ptr_q;
    hit_d        = hit_q;
    full_d       = full_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    found_d      = found_q;
    position_d   = position_q;
    table_full_d = table_full_q;
    used_d       = used_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          key_d  = key_i[KEY_BITS-1:0];
          lo_d   = '0;
          hi_d   = count_q;
          hit_d  = 1'b0;
          full_d = 1'b0;
        end
      end
      ST_SEARCH: begin
        if (!(lo_q < hi_q)) begin
          full_d = table_at_max;
          ptr_d  = AddrW'(count_q - CntW'(1));
        end
      end
      ST_COMPARE: begin
        if (key_q < ram_rdata) begin
          hi_d = mid;
        end else if (ram_rdata < key_q) begin
          lo_d = mid + CntW'(1);
        end else begin
          lo_d  = mid;
          hit_d = 1'b1;
        end
      end
      ST_SHIFT_WR: begin
        if (ptr_q != lo_q[AddrW-1:0]) ptr_d = ptr_q - AddrW'(1);
      end
      ST_INSERT: begin
        count_d = count_q + CntW'(1);
      end
      ST_REPLY: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          found_d      = hit_q;
          position_d   = lo_q;
          table_full_d = full_q;
          used_d       = count_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    ptr_q        <= ptr_d;
    hit_q        <= hit_d;
    full_q       <= full_d;
    found_q      <= found_d;
    position_q   <= position_d;
    table_full_q <= table_full_d;
    used_q       <= used_d;
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign position_o     = position_q;
  assign table_full_o   = table_full_q;
  assign entries_used_o = used_q;

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("key count exceeds table depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + CntW'(1)))
    else $error("key count changed by other than one");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_SHIFT_WR || state_q == ST_INSERT))
    else $error("RAM write outside shift or insert");

  a_accept_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_SEARCH))
    else $error("accepted key did not start a search");

  a_found_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(found_o && table_full_o))
    else $error("result reports both found and full");
`endif

endmodule
